### sv/spsc_pkg.sv
// Shared types, codes and reset values for the servo pulse sweep controller.
// No dependencies; imported by the top level, its checker and the testbench.
package spsc_pkg;

  // Pulse width precision and derived types
  localparam int PULSE_BITS = 12;
  localparam int SUM_BITS   = PULSE_BITS + 1;
  localparam int REQ_BITS   = 16;
  localparam int MS_BITS    = 16;
  localparam int STEP_BITS  = 8;
  localparam int MODE_BITS  = 8;
  localparam int CFG_BITS   = 16;

  typedef logic [PULSE_BITS-1:0] pulse_t;
  typedef logic [SUM_BITS-1:0]   pulse_sum_t;
  typedef logic [REQ_BITS-1:0]   req_t;
  typedef logic [MS_BITS-1:0]    ms_t;
  typedef logic [STEP_BITS-1:0]  step_t;
  typedef logic [MODE_BITS-1:0]  mode_req_t;
  typedef logic [CFG_BITS-1:0]   cfg_data_t;

  // Input action codes
  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_BUTTON = 3'd1,
    ACT_SET    = 3'd2,
    ACT_MODE   = 3'd3,
    ACT_BAD    = 3'd4
  } action_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_NONE       = 3'd0,
    ST_WIDTHS_SET = 3'd1,
    ST_NOW_MANUAL = 3'd2,
    ST_NOW_AUTO   = 3'd3,
    ST_MODE_ERROR = 3'd4,
    ST_BAD_LINE   = 3'd5
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_PULSE_FLOOR   = 3'd0,
    REG_PULSE_CEILING = 3'd1,
    REG_SWEEP_LOW     = 3'd2,
    REG_SWEEP_HIGH    = 3'd3,
    REG_SWEEP_STEP    = 3'd4,
    REG_STEP_INTERVAL = 3'd5,
    REG_HOLD_MS       = 3'd6
  } cfg_reg_t;

  // Mode request values
  localparam mode_req_t MODE_MANUAL_REQ = mode_req_t'(0);
  localparam mode_req_t MODE_AUTO_REQ   = mode_req_t'(1);

  // Reset values
  localparam pulse_t PULSE_FLOOR_RST   = pulse_t'(800);
  localparam pulse_t PULSE_CEILING_RST = pulse_t'(2200);
  localparam pulse_t SWEEP_LOW_RST     = pulse_t'(1200);
  localparam pulse_t SWEEP_HIGH_RST    = pulse_t'(1800);
  localparam step_t  SWEEP_STEP_RST    = step_t'(10);
  localparam ms_t    STEP_INTERVAL_RST = ms_t'(30);
  localparam ms_t    HOLD_MS_RST       = ms_t'(2000);
  localparam pulse_t PULSE_CENTER_RST  = pulse_t'(1500);

endpackage

### sv/servo_pulse_sweep_controller_top.sv
// Servo pulse sweep controller: config registers, mode/sweep/hold state, result register.
// Depends on spsc_pkg.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------------
//  item     | item_valid, item_ready  | action, width_first, width_second,
//           |                         | second_given, mode_request
//  result   | result_valid,           | width_a, width_b, auto_active, manual_led,
//           | result_ready            | holding, status
//  cfg      | cfg_valid, cfg_ready    | cfg_index, cfg_data
//
// Each item is decoded against the state registers in a single combinational pass of
// compares and adds, and its result appears in the result register on the next cycle.
// A new item is taken every cycle while the result side keeps up.
// item_ready drops only while a result waits and result_ready is low.
// Synchronous reset restores the default limits, manual mode and 1500 us outputs.
// cfg_ready is always high; writes take effect on the following cycle.
module servo_pulse_sweep_controller_top
  import spsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  // item channel
  input  logic      item_valid,
  output logic      item_ready,
  input  logic [2:0] action,
  input  req_t      width_first,
  input  req_t      width_second,
  input  logic      second_given,
  input  mode_req_t mode_request,
  // result channel
  output logic      result_valid,
  input  logic      result_ready,
  output pulse_t    width_a,
  output pulse_t    width_b,
  output logic      auto_active,
  output logic      manual_led,
  output logic      holding,
  output logic [2:0] status,
  // configuration channel
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  cfg_data_t cfg_data
);

  // Configuration registers
  pulse_t pulse_floor, pulse_ceiling, sweep_low, sweep_high;
  step_t  sweep_step;
  ms_t    step_interval_ms, hold_ms;

  // Controller state; out_a/out_b/auto_mode/hold_pending double as result fields
  logic    auto_mode, sweep_down, hold_pending;
  pulse_t  sweep_value, out_a, out_b;
  ms_t     since_step_ms, since_command_ms;
  status_t result_status;

  logic    auto_mode_next, sweep_down_next, hold_pending_next;
  pulse_t  sweep_value_next, out_a_next, out_b_next;
  ms_t     since_step_ms_next, since_command_ms_next;
  status_t result_status_next;

  logic       accept;
  logic       held;
  ms_t        step_cnt_inc, cmd_cnt_inc;
  pulse_t     clamp_first, clamp_second;
  pulse_sum_t sweep_raw;
  pulse_t     sweep_new;
  logic       sweep_turn_down, sweep_turn_up;

  // Clamp a requested width: floor first, then ceiling wins
  function automatic pulse_t clamp_width(input req_t w, input pulse_t lo, input pulse_t hi);
    req_t v;
    v = w;
    if (v < REQ_BITS'(lo)) v = REQ_BITS'(lo);
    if (v > REQ_BITS'(hi)) v = REQ_BITS'(hi);
    return v[PULSE_BITS-1:0];
  endfunction

  assign cfg_ready  = 1'b1;
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_floor      <= PULSE_FLOOR_RST;
      pulse_ceiling    <= PULSE_CEILING_RST;
      sweep_low        <= SWEEP_LOW_RST;
      sweep_high       <= SWEEP_HIGH_RST;
      sweep_step       <= SWEEP_STEP_RST;
      step_interval_ms <= STEP_INTERVAL_RST;
      hold_ms          <= HOLD_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PULSE_FLOOR:   pulse_floor      <= cfg_data[PULSE_BITS-1:0];
        REG_PULSE_CEILING: pulse_ceiling    <= cfg_data[PULSE_BITS-1:0];
        REG_SWEEP_LOW:     sweep_low        <= cfg_data[PULSE_BITS-1:0];
        REG_SWEEP_HIGH:    sweep_high       <= cfg_data[PULSE_BITS-1:0];
        REG_SWEEP_STEP:    sweep_step       <= cfg_data[STEP_BITS-1:0];
        REG_STEP_INTERVAL: step_interval_ms <= cfg_data[MS_BITS-1:0];
        REG_HOLD_MS:       hold_ms          <= cfg_data[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Saturating elapsed counters
  assign step_cnt_inc = (since_step_ms == '1) ? since_step_ms : since_step_ms + ms_t'(1);
  assign cmd_cnt_inc  = (since_command_ms == '1) ? since_command_ms
                                                 : since_command_ms + ms_t'(1);
  assign held = hold_pending && (cmd_cnt_inc < hold_ms);

  // Requested widths after clamping
  assign clamp_first  = clamp_width(width_first, pulse_floor, pulse_ceiling);
  assign clamp_second = clamp_width(width_second, pulse_floor, pulse_ceiling);

  // Triangle sweep step: move, floor at zero, then fold at the bounds
  always_comb begin
    if (sweep_down) begin
      sweep_raw = (sweep_value >= PULSE_BITS'(sweep_step))
                ? SUM_BITS'(sweep_value) - SUM_BITS'(sweep_step) : '0;
    end else begin
      sweep_raw = SUM_BITS'(sweep_value) + SUM_BITS'(sweep_step);
    end
    sweep_turn_down = sweep_raw >= SUM_BITS'(sweep_high);
    sweep_turn_up   = !sweep_turn_down && (sweep_raw <= SUM_BITS'(sweep_low));
    if (sweep_turn_down)    sweep_new = sweep_high;
    else if (sweep_turn_up) sweep_new = sweep_low;
    else                    sweep_new = sweep_raw[PULSE_BITS-1:0];
  end

  // Decode the action and form the next state
  always_comb begin
    auto_mode_next        = auto_mode;
    sweep_down_next       = sweep_down;
    hold_pending_next     = hold_pending;
    sweep_value_next      = sweep_value;
    out_a_next            = out_a;
    out_b_next            = out_b;
    since_step_ms_next    = since_step_ms;
    since_command_ms_next = since_command_ms;
    result_status_next    = ST_NONE;
    unique case (action_t'(action))
      ACT_TICK: begin
        since_step_ms_next    = step_cnt_inc;
        since_command_ms_next = cmd_cnt_inc;
        if (auto_mode && !held && (step_cnt_inc >= step_interval_ms)) begin
          hold_pending_next  = 1'b0;
          since_step_ms_next = '0;
          sweep_value_next   = sweep_new;
          out_a_next         = sweep_new;
          out_b_next         = sweep_new;
          if (sweep_turn_down)    sweep_down_next = 1'b1;
          else if (sweep_turn_up) sweep_down_next = 1'b0;
        end
      end
      ACT_BUTTON: begin
        if (auto_mode) begin
          auto_mode_next     = 1'b0;
          result_status_next = ST_NOW_MANUAL;
        end else begin
          auto_mode_next     = 1'b1;
          sweep_value_next   = sweep_low;
          sweep_down_next    = 1'b0;
          since_step_ms_next = '0;
          hold_pending_next  = 1'b0;
          result_status_next = ST_NOW_AUTO;
        end
      end
      ACT_SET: begin
        out_a_next            = clamp_first;
        out_b_next            = second_given ? clamp_second : clamp_first;
        sweep_value_next      = clamp_first;
        hold_pending_next     = 1'b1;
        since_command_ms_next = '0;
        result_status_next    = ST_WIDTHS_SET;
      end
      ACT_MODE: begin
        if (mode_request == MODE_AUTO_REQ) begin
          auto_mode_next     = 1'b1;
          result_status_next = ST_NOW_AUTO;
        end else if (mode_request == MODE_MANUAL_REQ) begin
          auto_mode_next     = 1'b0;
          result_status_next = ST_NOW_MANUAL;
        end else begin
          result_status_next = ST_MODE_ERROR;
        end
      end
      ACT_BAD: result_status_next = ST_BAD_LINE;
      default: ;
    endcase
  end

  // Commit state and result on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_mode        <= 1'b0;
      sweep_down       <= 1'b0;
      hold_pending     <= 1'b0;
      sweep_value      <= PULSE_CENTER_RST;
      out_a            <= PULSE_CENTER_RST;
      out_b            <= PULSE_CENTER_RST;
      since_step_ms    <= '0;
      since_command_ms <= '0;
      result_status    <= ST_NONE;
    end else if (accept) begin
      auto_mode        <= auto_mode_next;
      sweep_down       <= sweep_down_next;
      hold_pending     <= hold_pending_next;
      sweep_value      <= sweep_value_next;
      out_a            <= out_a_next;
      out_b            <= out_b_next;
      since_step_ms    <= since_step_ms_next;
      since_command_ms <= since_command_ms_next;
      result_status    <= result_status_next;
    end
  end

  // Result valid: set on accept, drop when taken with nothing new behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  assign width_a     = out_a;
  assign width_b     = out_b;
  assign auto_active = auto_mode;
  assign manual_led  = !auto_mode;
  assign holding     = hold_pending;
  assign status      = result_status;

endmodule

### sv/spsc_checker.sv
// Port-level checker for the servo pulse sweep controller, bound to the top level.
// Depends on spsc_pkg and servo_pulse_sweep_controller_top.
module spsc_checker
  import spsc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_ready,
  input logic [2:0] action,
  input logic      result_valid,
  input logic      result_ready,
  input pulse_t    width_a,
  input pulse_t    width_b,
  input logic      auto_active,
  input logic      manual_led,
  input logic      holding,
  input logic [2:0] status
);

  // Hold a stalled result steady
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(width_a) && $stable(width_b)
      && $stable(status) && $stable(holding) && $stable(auto_active))
    else $error("stalled result changed");

  // Every accepted item produces a result on the next cycle
  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> result_valid)
    else $error("accepted item gave no result");

  // A set command reports widths set and starts a hold
  a_set_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && action == ACT_SET |=> status == ST_WIDTHS_SET && holding)
    else $error("set command did not start a hold");

  // Manual indicator is the inverse of the auto flag
  a_led: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> manual_led == !auto_active)
    else $error("manual indicator disagrees with mode");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind servo_pulse_sweep_controller_top spsc_checker u_spsc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .action       (action),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .width_a      (width_a),
  .width_b      (width_b),
  .auto_active  (auto_active),
  .manual_led   (manual_led),
  .holding      (holding),
  .status       (status)
);

### tb/servo_pulse_sweep_controller_top_test.sv
// Self-checking testbench for servo_pulse_sweep_controller_top: a directed table, random phases
// under several register settings and a closing manual-to-auto run, each result checked against a local model.
// Depends on spsc_pkg and the servo_pulse_sweep_controller_top RTL.
module servo_pulse_sweep_controller_top_test import spsc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Action codes the block leaves unused
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          IDLE_PCT    = 11;
  localparam int          LONG_TICKS  = 60;
  localparam ms_t         MS_MAX      = '1;

  typedef struct packed {
    pulse_t  width_a;
    pulse_t  width_b;
    logic    auto_active;
    logic    manual_led;
    logic    holding;
    status_t status;
  } servo_res_t;

  typedef struct {
    logic [2:0] act;
    req_t       w1;
    req_t       w2;
    logic       sec;
    mode_req_t  req;
    logic       pinned;
    servo_res_t res;
  } plan_row_t;

  localparam servo_res_t UNPINNED = '{12'd0, 12'd0, 1'b0, 1'b0, 1'b0, ST_NONE};

  // Block ports
  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_ready;
  logic [2:0] action       = '0;
  req_t       width_first  = '0;
  req_t       width_second = '0;
  logic       second_given = 1'b0;
  mode_req_t  mode_request = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  pulse_t     width_a;
  pulse_t     width_b;
  logic       auto_active;
  logic       manual_led;
  logic       holding;
  logic [2:0] status;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index    = '0;
  cfg_data_t  cfg_data     = '0;

  // Model of the controller: registers and state
  pulse_t cf_floor, cf_ceiling, cf_low, cf_high;
  step_t  cf_step;
  ms_t    cf_interval, cf_hold;
  logic   auto_mode, sweep_down, hold_pending;
  pulse_t sweep_value, out_a, out_b;
  ms_t    since_step, since_cmd;

  // Expected outputs, oldest first, and run bookkeeping
  servo_res_t  pending_outputs[$];
  plan_row_t   plan[$];
  logic        pin_on  = 1'b0;
  servo_res_t  pin_res = UNPINNED;
  logic        no_gaps = 1'b0;
  int unsigned errors = 0;
  int unsigned items_seen = 0;
  int unsigned results_seen = 0;
  int unsigned writes_seen = 0;
  int unsigned settings = 0;
  int unsigned sweeps_taken = 0;
  int unsigned cycle_count = 0;

  servo_pulse_sweep_controller_top dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result side now and then
  always @(negedge clk) begin
    result_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void reset_servo_model();
    cf_floor     = PULSE_FLOOR_RST;
    cf_ceiling   = PULSE_CEILING_RST;
    cf_low       = SWEEP_LOW_RST;
    cf_high      = SWEEP_HIGH_RST;
    cf_step      = SWEEP_STEP_RST;
    cf_interval  = STEP_INTERVAL_RST;
    cf_hold      = HOLD_MS_RST;
    auto_mode    = 1'b0;
    sweep_down   = 1'b0;
    hold_pending = 1'b0;
    sweep_value  = PULSE_CENTER_RST;
    out_a        = PULSE_CENTER_RST;
    out_b        = PULSE_CENTER_RST;
    since_step   = '0;
    since_cmd    = '0;
  endfunction

  // Floor first, then ceiling, so a crossed pair yields the ceiling
  function automatic pulse_t clamp_request(req_t w);
    int v;
    v = w;
    if (v < int'(cf_floor)) v = cf_floor;
    if (v > int'(cf_ceiling)) v = cf_ceiling;
    return pulse_t'(v);
  endfunction

  // Apply one item to the model and return the outputs it leaves
  function automatic servo_res_t next_servo_outputs(logic [2:0] act, req_t w1, req_t w2,
                                                    logic sec, mode_req_t req);
    status_t st;
    pulse_t  a;
    int      v;
    st = ST_NONE;
    case (act)
      ACT_TICK: begin
        if (since_step != MS_MAX) since_step++;
        if (since_cmd != MS_MAX) since_cmd++;
        if (auto_mode && !(hold_pending && since_cmd < cf_hold) &&
            since_step >= cf_interval) begin
          hold_pending = 1'b0;
          since_step   = '0;
          if (sweep_down)
            v = (sweep_value >= cf_step) ? int'(sweep_value) - int'(cf_step) : 0;
          else
            v = int'(sweep_value) + int'(cf_step);
          if (v >= int'(cf_high)) begin
            v = cf_high;
            sweep_down = 1'b1;
          end else if (v <= int'(cf_low)) begin
            v = cf_low;
            sweep_down = 1'b0;
          end
          sweep_value = pulse_t'(v);
          out_a = sweep_value;
          out_b = sweep_value;
          sweeps_taken++;
        end
      end
      ACT_BUTTON: begin
        if (auto_mode) begin
          auto_mode = 1'b0;
          st = ST_NOW_MANUAL;
        end else begin
          auto_mode    = 1'b1;
          sweep_value  = cf_low;
          sweep_down   = 1'b0;
          since_step   = '0;
          hold_pending = 1'b0;
          st = ST_NOW_AUTO;
        end
      end
      ACT_SET: begin
        a = clamp_request(w1);
        out_a = a;
        out_b = sec ? clamp_request(w2) : a;
        sweep_value  = a;
        hold_pending = 1'b1;
        since_cmd    = '0;
        st = ST_WIDTHS_SET;
      end
      ACT_MODE: begin
        if (req <= MODE_AUTO_REQ) begin
          auto_mode = (req == MODE_AUTO_REQ);
          st = auto_mode ? ST_NOW_AUTO : ST_NOW_MANUAL;
        end else begin
          st = ST_MODE_ERROR;
        end
      end
      ACT_BAD: st = ST_BAD_LINE;
      default: ;
    endcase
    return '{out_a, out_b, auto_mode, !auto_mode, hold_pending, st};
  endfunction

  task automatic check_field(string what, logic [11:0] exp_v, logic [11:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, exp_v, got_v);
      errors++;
    end
  endtask

  // Mirror register writes, check results, predict accepted items
  always @(posedge clk) begin : monitor
    servo_res_t want;
    if (rst) begin
      reset_servo_model();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PULSE_FLOOR:   cf_floor    = cfg_data[PULSE_BITS-1:0];
          REG_PULSE_CEILING: cf_ceiling  = cfg_data[PULSE_BITS-1:0];
          REG_SWEEP_LOW:     cf_low      = cfg_data[PULSE_BITS-1:0];
          REG_SWEEP_HIGH:    cf_high     = cfg_data[PULSE_BITS-1:0];
          REG_SWEEP_STEP:    cf_step     = cfg_data[STEP_BITS-1:0];
          REG_STEP_INTERVAL: cf_interval = cfg_data;
          REG_HOLD_MS:       cf_hold     = cfg_data;
          default: ;
        endcase
        writes_seen++;
      end
      if (result_valid && result_ready) begin
        if (pending_outputs.size() == 0) begin
          $display("%0t: result with nothing expected, actual width_a %0d status %0d",
                   $time, width_a, status);
          errors++;
        end else begin
          want = pending_outputs.pop_front();
          check_field("width_a", want.width_a, width_a);
          check_field("width_b", want.width_b, width_b);
          check_field("auto_active", 12'(want.auto_active), 12'(auto_active));
          check_field("manual_led", 12'(want.manual_led), 12'(manual_led));
          check_field("holding", 12'(want.holding), 12'(holding));
          check_field("status", 12'(want.status), 12'(status));
          results_seen++;
        end
      end
      if (item_valid && item_ready) begin
        want = next_servo_outputs(action, width_first, width_second, second_given,
                                  mode_request);
        if (pin_on) want = pin_res;
        pending_outputs.push_back(want);
        items_seen++;
      end
    end
  end

  // Present one item at a falling edge, hold it until taken
  task automatic send_item(logic [2:0] act, req_t w1, req_t w2, logic sec, mode_req_t req,
                           logic pinned, servo_res_t res);
    @(negedge clk);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid   <= 1'b1;
    action       <= act;
    width_first  <= w1;
    width_second <= w2;
    second_given <= sec;
    mode_request <= req;
    pin_on  = pinned;
    pin_res = res;
    do @(posedge clk); while (!(item_valid && item_ready));
  endtask

  // Widths: full range, pulse range, near the limits, or the extremes
  function automatic req_t pick_width();
    int v;
    case ($urandom_range(3))
      0: v = $urandom_range(65535);
      1: v = $urandom_range(4095);
      2: begin
        v = ($urandom_range(1) ? int'(cf_floor) : int'(cf_ceiling)) + $urandom_range(4) - 2;
        if (v < 0) v = 0;
      end
      default: v = $urandom_range(1) ? 65535 : 0;
    endcase
    return req_t'(v);
  endfunction

  // Mostly ticks so the sweep gets to move; the rest commands and noise
  task automatic send_random_item();
    int         pick;
    logic [2:0] act;
    mode_req_t  req;
    pick = $urandom_range(99);
    if (pick < 70)      act = ACT_TICK;
    else if (pick < 77) act = ACT_SET;
    else if (pick < 82) act = ACT_BUTTON;
    else if (pick < 90) act = ACT_MODE;
    else if (pick < 95) act = ACT_BAD;
    else                act = 3'($urandom_range(ACT_SPARE_5, ACT_SPARE_7));
    pick = $urandom_range(9);
    if (pick < 6)      req = MODE_AUTO_REQ;
    else if (pick < 8) req = MODE_MANUAL_REQ;
    else               req = mode_req_t'($urandom_range(255));
    send_item(act, pick_width(), pick_width(), 1'($urandom_range(1)), req, 1'b0, UNPINNED);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= cfg_data_t'(val);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
  endtask

  task automatic program_limits(int unsigned lo_lim, int unsigned hi_lim, int unsigned low_v,
                                int unsigned high_v, int unsigned step_v,
                                int unsigned intv_v, int unsigned hold_v);
    write_reg(REG_PULSE_FLOOR, lo_lim);
    write_reg(REG_PULSE_CEILING, hi_lim);
    write_reg(REG_SWEEP_LOW, low_v);
    write_reg(REG_SWEEP_HIGH, high_v);
    write_reg(REG_SWEEP_STEP, step_v);
    write_reg(REG_STEP_INTERVAL, intv_v);
    write_reg(REG_HOLD_MS, hold_v);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Drop valid and wait until every expected result is back
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_random();
    int unsigned lo_lim, hi_lim, low_v, high_v;
    lo_lim = $urandom_range(4095);
    hi_lim = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(lo_lim, 4095);
    low_v  = $urandom_range(3000);
    high_v = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(low_v, 4095);
    program_limits(lo_lim, hi_lim, low_v, high_v,
                   $urandom_range(1) ? $urandom_range(1, 40) : $urandom_range(1, 255),
                   $urandom_range(1, 6), $urandom_range(0, 25));
  endtask

  initial begin : stimulus
    int p;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table under the reset limits
    plan.push_back('{ACT_TICK, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b1,
                     '{PULSE_CENTER_RST, PULSE_CENTER_RST, 1'b0, 1'b1, 1'b0, ST_NONE}});
    plan.push_back('{ACT_SET, 16'd0, 16'hFFFF, 1'b0, MODE_MANUAL_REQ, 1'b1,
                     '{PULSE_FLOOR_RST, PULSE_FLOOR_RST, 1'b0, 1'b1, 1'b1, ST_WIDTHS_SET}});
    plan.push_back('{ACT_SET, 16'hFFFF, 16'd0, 1'b1, MODE_MANUAL_REQ, 1'b1,
                     '{PULSE_CEILING_RST, PULSE_FLOOR_RST, 1'b0, 1'b1, 1'b1, ST_WIDTHS_SET}});
    plan.push_back('{ACT_MODE, 16'd0, 16'd0, 1'b0, 8'hFF, 1'b1,
                     '{PULSE_CEILING_RST, PULSE_FLOOR_RST, 1'b0, 1'b1, 1'b1, ST_MODE_ERROR}});
    plan.push_back('{ACT_BAD, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1,
                     '{PULSE_CEILING_RST, PULSE_FLOOR_RST, 1'b0, 1'b1, 1'b1, ST_BAD_LINE}});
    plan.push_back('{ACT_MODE, 16'd0, 16'd0, 1'b0, 8'd2, 1'b0, UNPINNED});
    plan.push_back('{ACT_SPARE_5, 16'hA5A5, 16'h5A5A, 1'b1, 8'h80, 1'b0, UNPINNED});
    plan.push_back('{ACT_SPARE_6, 16'h5A5A, 16'hA5A5, 1'b0, 8'h7F, 1'b0, UNPINNED});
    plan.push_back('{ACT_SPARE_7, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b0, UNPINNED});
    plan.push_back('{ACT_MODE, 16'd0, 16'd0, 1'b0, MODE_AUTO_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_TICK, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_TICK, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_SET, 16'd1500, 16'hFFFF, 1'b1, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_BUTTON, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_BUTTON, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_TICK, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_MODE, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_MODE, 16'd0, 16'd0, 1'b0, MODE_AUTO_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_SET, 16'd800, 16'd2200, 1'b1, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_SET, 16'd799, 16'd2201, 1'b1, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    plan.push_back('{ACT_TICK, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED});
    foreach (plan[i])
      send_item(plan[i].act, plan[i].w1, plan[i].w2, plan[i].sec, plan[i].req,
                plan[i].pinned, plan[i].res);
    settle();

    // Register extremes: widest limits, fastest sweep, no hold
    program_limits(0, 4095, 0, 4095, 255, 1, 0);
    repeat (200) send_random_item();
    settle();

    // Crossed limits, slowest sweep, longest hold
    program_limits(4095, 0, 4095, 0, 1, 65535, 65535);
    repeat (150) send_random_item();
    settle();

    // Zero step and zero interval
    program_limits(500, 3500, 1000, 3000, 0, 0, 5);
    repeat (200) send_random_item();
    settle();

    // Back-to-back items, no stalls on either side
    no_gaps = 1'b1;
    program_random();
    repeat (250) send_random_item();
    settle();
    no_gaps = 1'b0;

    for (p = 0; p < 5; p++) begin
      program_random();
      repeat (200) send_random_item();
      settle();
    end

    // Run both elapsed counters past the interval and hold in manual mode,
    // then step on the first tick in auto
    program_limits(800, 2200, 1200, 1800, 10, 50, 40);
    send_item(ACT_MODE, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED);
    send_item(ACT_SET, 16'd1234, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED);
    repeat (LONG_TICKS)
      send_item(ACT_TICK, pick_width(), pick_width(), 1'($urandom_range(1)),
                mode_req_t'($urandom_range(255)), 1'b0, UNPINNED);
    send_item(ACT_MODE, 16'd0, 16'd0, 1'b0, MODE_AUTO_REQ, 1'b0, UNPINNED);
    repeat (3) send_item(ACT_TICK, 16'd0, 16'd0, 1'b0, MODE_MANUAL_REQ, 1'b0, UNPINNED);
    settle();
    repeat (8) @(posedge clk);

    $display("Run covered %0d items under %0d register settings (%0d writes), with a %0d-tick",
             items_seen, settings + 1, writes_seen, LONG_TICKS);
    $display("manual run before auto; %0d results compared, %0d sweep steps taken",
             results_seen, sweeps_taken);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
